/* rtl/core/ipdf_pkg.sv */
// Package for the IPv4 port drop filter: payload types, codes and constants.
package ipdf_pkg;

    localparam int COUNTER_WIDTH_DEF  = 32;
    localparam int POSITION_WIDTH_DEF = 16;

    localparam int CFG_INDEX_WIDTH = 8;
    localparam int PORT_WIDTH      = 16;
    localparam int COUNT_OUT_WIDTH = 32;

    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_TCP_DROP_PORT = 8'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_UDP_DROP_PORT = 8'd1;

    localparam logic [PORT_WIDTH-1:0] TCP_DROP_PORT_RESET = 16'd23;
    localparam logic [PORT_WIDTH-1:0] UDP_DROP_PORT_RESET = 16'd0;

    localparam logic [7:0] PROTO_TCP    = 8'd6;
    localparam logic [7:0] PROTO_UDP    = 8'd17;
    localparam logic [3:0] IP_VERSION_4 = 4'd4;

    localparam logic [PORT_WIDTH-1:0] PORT_TELNET     = 16'd23;
    localparam logic [PORT_WIDTH-1:0] PORT_TELNET_ALT = 16'd2323;
    localparam logic [PORT_WIDTH-1:0] PORT_SSDP       = 16'd1900;

    // The last transport header byte sits at four times the header length plus these.
    localparam logic [6:0] TCP_HDR_LAST = 7'd19;
    localparam logic [6:0] UDP_HDR_LAST = 7'd7;
    localparam int         PROTO_OFFSET = 9;

    localparam logic [2:0] REASON_NONE     = 3'd0;
    localparam logic [2:0] REASON_TCP23    = 3'd1;
    localparam logic [2:0] REASON_TCP2323  = 3'd2;
    localparam logic [2:0] REASON_UDP1900  = 3'd3;
    localparam logic [2:0] REASON_TCP_REG  = 3'd4;
    localparam logic [2:0] REASON_UDP_REG  = 3'd5;

    typedef struct packed {
        logic [7:0] packet_byte;
        logic       last_byte;
    } t_in_item;

    typedef struct packed {
        logic                       verdict;
        logic [2:0]                 reason;
        logic [COUNT_OUT_WIDTH-1:0] packets_seen;
        logic [COUNT_OUT_WIDTH-1:0] packets_dropped;
    } t_out_item;

endpackage

/* rtl/core/ipdf_skid.sv */
// Output register with a skid stage for the verdict channel.
module ipdf_skid (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  ipdf_pkg::t_out_item i_data,
    output logic               o_ready,
    output logic               o_valid,
    output ipdf_pkg::t_out_item o_data,
    input  logic               i_ready
);
    import ipdf_pkg::*;

    logic      r_out_valid;
    logic      r_skid_valid;
    t_out_item r_out;
    t_out_item r_skid;
    logic      n_out_valid;
    logic      n_skid_valid;
    t_out_item n_out;
    t_out_item n_skid;

    assign o_ready = !r_skid_valid;
    assign o_valid = r_out_valid;
    assign o_data  = r_out;

    always_comb begin
        n_out_valid  = r_out_valid;
        n_skid_valid = r_skid_valid;
        n_out        = r_out;
        n_skid       = r_skid;
        if (!r_out_valid || i_ready) begin
            if (r_skid_valid) begin
                n_out_valid  = 1'b1;
                n_out        = r_skid;
                n_skid_valid = 1'b0;
            end else begin
                n_out_valid = i_valid;
                n_out       = i_data;
            end
        end else if (i_valid && !r_skid_valid) begin
            n_skid_valid = 1'b1;
            n_skid       = i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_skid <= n_skid;
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

endmodule

/* rtl/core/ipv4_port_drop_filter_unit.sv */
// Top level of the IPv4 destination port drop filter.
//
//  Channel  Direction  Handshake                   Payload
//  in       sink       i_in_valid / o_in_ready     i_in_data (packet byte, last mark)
//  out      source     o_out_valid / i_out_ready   o_out_data (verdict, reason, counters)
//  cfg      sink       i_cfg_valid / o_cfg_ready   i_cfg_index, i_cfg_data
//
// One byte is taken per cycle unless the skid stage is full; a packet's verdict is
// registered from its last byte. The header parse and the rule match are combinational,
// between the packet state registers and the output register.
// Reset sets the drop ports to their reset values and clears the packet state and counters.
// A stalled output holds one verdict in a skid stage; input stalls only when it is full.
module ipv4_port_drop_filter_unit #(
    parameter int COUNTER_WIDTH  = ipdf_pkg::COUNTER_WIDTH_DEF,
    parameter int POSITION_WIDTH = ipdf_pkg::POSITION_WIDTH_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_in_valid,
    output logic                                   o_in_ready,
    input  ipdf_pkg::t_in_item                     i_in_data,
    output logic                                   o_out_valid,
    input  logic                                   i_out_ready,
    output ipdf_pkg::t_out_item                    o_out_data,
    input  logic                                   i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  logic [ipdf_pkg::CFG_INDEX_WIDTH-1:0]   i_cfg_index,
    input  logic [ipdf_pkg::PORT_WIDTH-1:0]        i_cfg_data
);
    import ipdf_pkg::*;

    localparam logic [POSITION_WIDTH-1:0] POS_MAX = {POSITION_WIDTH{1'b1}};

    logic [PORT_WIDTH-1:0]     r_tcp_port;
    logic [PORT_WIDTH-1:0]     r_udp_port;
    logic [POSITION_WIDTH-1:0] r_pos;
    logic [3:0]                r_hw;
    logic                      r_ipv4;
    logic [7:0]                r_proto;
    logic [PORT_WIDTH-1:0]     r_port;
    logic [COUNTER_WIDTH-1:0]  r_seen;
    logic [COUNTER_WIDTH-1:0]  r_dropped;

    logic [COUNTER_WIDTH-1:0]  n_seen;
    logic [COUNTER_WIDTH-1:0]  n_dropped;

    logic                      w_accept;
    logic                      w_last;
    logic [7:0]                w_byte;
    logic                      w_at0;
    logic                      w_ipv4;
    logic [3:0]                w_hw;
    logic [7:0]                w_proto;
    logic [POSITION_WIDTH-1:0] w_port_hi_pos;
    logic [POSITION_WIDTH-1:0] w_port_lo_pos;
    logic [PORT_WIDTH-1:0]     w_port;
    logic [6:0]                w_need_last;
    logic                      w_is_tcp;
    logic                      w_is_udp;
    logic                      w_long;
    logic [2:0]                w_reason;
    logic                      w_drop;
    logic                      w_skid_ready;
    logic [COUNTER_WIDTH+COUNT_OUT_WIDTH-1:0] w_seen_ext;
    logic [COUNTER_WIDTH+COUNT_OUT_WIDTH-1:0] w_dropped_ext;
    t_out_item                 w_result;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = w_skid_ready;
    assign w_accept    = i_in_valid && w_skid_ready;
    assign w_last      = i_in_data.last_byte;
    assign w_byte      = i_in_data.packet_byte;

    assign w_at0   = (r_pos == '0);
    assign w_ipv4  = w_at0 ? (w_byte[7:4] == IP_VERSION_4) : r_ipv4;
    assign w_hw    = w_at0 ? w_byte[3:0] : r_hw;
    assign w_proto = (r_pos == POSITION_WIDTH'(PROTO_OFFSET)) ? w_byte : r_proto;

    assign w_port_hi_pos = POSITION_WIDTH'({w_hw, 2'b10});
    assign w_port_lo_pos = POSITION_WIDTH'({w_hw, 2'b11});
    assign w_port[15:8]  = (r_pos == w_port_hi_pos) ? w_byte : r_port[15:8];
    assign w_port[7:0]   = (r_pos == w_port_lo_pos) ? w_byte : r_port[7:0];

    assign w_is_tcp    = (w_proto == PROTO_TCP);
    assign w_is_udp    = (w_proto == PROTO_UDP);
    assign w_need_last = {1'b0, w_hw, 2'b00} + (w_is_tcp ? TCP_HDR_LAST : UDP_HDR_LAST);
    assign w_long      = (r_pos >= POSITION_WIDTH'(w_need_last));

    always_comb begin
        w_reason = REASON_NONE;
        if (w_ipv4 && w_long) begin
            if (w_is_tcp && w_port == PORT_TELNET) begin
                w_reason = REASON_TCP23;
            end else if (w_is_tcp && w_port == PORT_TELNET_ALT) begin
                w_reason = REASON_TCP2323;
            end else if (w_is_udp && w_port == PORT_SSDP) begin
                w_reason = REASON_UDP1900;
            end else if (w_is_tcp && r_tcp_port != '0 && w_port == r_tcp_port) begin
                w_reason = REASON_TCP_REG;
            end else if (w_is_udp && r_udp_port != '0 && w_port == r_udp_port) begin
                w_reason = REASON_UDP_REG;
            end
        end
    end

    assign w_drop    = (w_reason != REASON_NONE);
    assign n_seen    = w_ipv4 ? r_seen + COUNTER_WIDTH'(1) : r_seen;
    assign n_dropped = w_drop ? r_dropped + COUNTER_WIDTH'(1) : r_dropped;

    assign w_seen_ext    = {{COUNT_OUT_WIDTH{1'b0}}, n_seen};
    assign w_dropped_ext = {{COUNT_OUT_WIDTH{1'b0}}, n_dropped};

    always_comb begin
        w_result.verdict         = w_drop;
        w_result.reason          = w_reason;
        w_result.packets_seen    = w_seen_ext[COUNT_OUT_WIDTH-1:0];
        w_result.packets_dropped = w_dropped_ext[COUNT_OUT_WIDTH-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tcp_port <= TCP_DROP_PORT_RESET;
            r_udp_port <= UDP_DROP_PORT_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_TCP_DROP_PORT: r_tcp_port <= i_cfg_data;
                CFG_UDP_DROP_PORT: r_udp_port <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos     <= '0;
            r_hw      <= '0;
            r_ipv4    <= 1'b0;
            r_proto   <= '0;
            r_port    <= '0;
            r_seen    <= '0;
            r_dropped <= '0;
        end else if (w_accept) begin
            if (w_last) begin
                r_pos     <= '0;
                r_hw      <= '0;
                r_ipv4    <= 1'b0;
                r_proto   <= '0;
                r_port    <= '0;
                r_seen    <= n_seen;
                r_dropped <= n_dropped;
            end else begin
                r_pos   <= (r_pos == POS_MAX) ? r_pos : r_pos + POSITION_WIDTH'(1);
                r_hw    <= w_hw;
                r_ipv4  <= w_ipv4;
                r_proto <= w_proto;
                r_port  <= w_port;
            end
        end
    end

    ipdf_skid u_skid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_accept && w_last),
        .i_data  (w_result),
        .o_ready (w_skid_ready),
        .o_valid (o_out_valid),
        .o_data  (o_out_data),
        .i_ready (i_out_ready)
    );

    a_verdict_reason: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.verdict == (o_out_data.reason != REASON_NONE)))
        else $error("verdict and reason disagree");

    a_mid_packet_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && !w_last) |=> (r_seen == $past(r_seen) && r_dropped == $past(r_dropped)))
        else $error("counters moved on a byte that is not the last");

    a_drop_is_seen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && r_dropped != $past(r_dropped)) |-> (r_seen != $past(r_seen)))
        else $error("drop counted without the packet being counted as seen");

    a_stall_has_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> o_out_valid)
        else $error("input stalled with no verdict waiting");

endmodule
